// File: src/pcs_pkg.sv
// Shared types, constants and the erf lookup table for the pattern causality strength block.
package pcs_pkg;

	localparam int MAX_LEN     = 64;
	localparam int CNT_W       = $clog2(MAX_LEN + 1);
	localparam int ADDR_W      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int VAL_W       = 24;
	localparam int SUM_W       = 54;
	localparam int SQ_W        = 2 * VAL_W;
	localparam int DEN_W       = SUM_W + 4;
	localparam int REM_W       = DEN_W + 1;
	localparam int ERF_ENTRIES = 256;
	localparam int IDX_W       = $clog2(ERF_ENTRIES);
	localparam int QUO_W       = 2 * IDX_W;
	localparam int STEP_W      = $clog2(QUO_W);
	localparam int STR_W       = 17;

	localparam logic [STR_W-1:0] STRENGTH_ONE = STR_W'(65536);
	localparam logic [SUM_W-1:0] SUM_MAX      = {SUM_W{1'b1}};

	typedef enum logic [2:0] {
		ACT_PRED_PAT = 3'd0,
		ACT_REAL_PAT = 3'd1,
		ACT_X_PAT    = 3'd2,
		ACT_PRED_SIG = 3'd3,
		ACT_REAL_SIG = 3'd4,
		ACT_X_SIG    = 3'd5,
		ACT_EVAL     = 3'd6,
		ACT_NONE     = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		STS_OK         = 3'd0,
		STS_MISSING    = 3'd1,
		STS_EMPTY_PRED = 3'd2,
		STS_EMPTY_X    = 3'd3,
		STS_TOO_LONG   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_PSTART,
		ST_PWAIT,
		ST_RSTART,
		ST_RWAIT
	} state_t;

	typedef enum logic [1:0] {
		U_IDLE,
		U_DIV,
		U_SQRT
	} ustate_t;

	// request and answer between the sequencer and the div/sqrt unit
	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] sy;
		logic [SUM_W-1:0] sx;
	} dsq_req_t;

	typedef struct packed {
		logic             done;
		logic             sat;
		logic [IDX_W-1:0] idx;
	} dsq_res_t;

	typedef logic [STR_W-1:0] erf_tab_t [ERF_ENTRIES];

	// exp(-u) in Q.30: fourth-order series at u/256, squared eight times
	function automatic longint unsigned exp_neg_q30(longint unsigned u30);
		longint unsigned s, t2, t3, t4, e;
		s  = u30 >> 8;
		t2 = ((s * s) >> 30) >> 1;
		// divide by 3 as a reciprocal multiply, exact for operands below 2^32
		t3 = ((((t2 * s) >> 30) * 64'hAAAAAAAB) >> 33);
		t4 = ((t3 * s) >> 30) >> 2;
		e  = (64'd1 << 30) - s + t2 - t3 + t4;
		for (int k = 0; k < 8; k++) begin
			e = (e * e) >> 30;
		end
		return e;
	endfunction

	function automatic longint unsigned sample_at(longint unsigned j);
		return exp_neg_q30(((j * j) << 32) >> (2 * IDX_W));
	endfunction

	// Simpson integration of 2/sqrt(pi)*exp(-t^2), entry i at t = 4i/ERF_ENTRIES
	function automatic erf_tab_t build_erf();
		erf_tab_t        tab;
		longint unsigned acc, j, a, v;
		acc    = 0;
		tab[0] = '0;
		for (int i = 1; i < ERF_ENTRIES; i++) begin
			j   = 64'(2 * (i - 1));
			acc = acc + sample_at(j) + 4 * sample_at(j + 1) + sample_at(j + 2);
			a   = (acc >> IDX_W) >> 6;
			v   = (a * 64'd3230901080 + (64'd1 << 39)) >> 40;
			tab[i] = (v > 64'd65536) ? STRENGTH_ONE : STR_W'(v);
		end
		return tab;
	endfunction

	localparam erf_tab_t ERF_TABLE = build_erf();

endpackage

// File: src/pattern_causality_strength.sv
// Top level: element loading, pattern store, square sums and evaluate sequencer.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid, in_stall, action/value/missing | in
//  out     | out_valid, out_stall, status/strengths | out
//  cfg     | cfg_we, cfg_wdata (weighted_mode)      | in
//
// Load beats need no extra state; a real-pattern beat with a stored partner goes
// through ST_CMP (registered store read, then compare).
// An evaluate beat with erf weighting runs the div/sqrt unit twice, each pass
// a start, the 16-bit divide, the 8-bit root and a done step; a saturated ratio
// skips divide and root. Any other evaluate gives a registered result directly.
// Reset clears counts, flags, sums and weighted_mode; the store is not cleared.
// in_stall is high while a beat is in work or a result waits on out_stall.
module pattern_causality_strength (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    action,
	input  logic signed [23:0]            value,
	input  logic                          missing,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    status,
	output logic [pcs_pkg::STR_W-1:0]     predicted_strength,
	output logic [pcs_pkg::STR_W-1:0]     real_strength,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata
);

	pcs_pkg::state_t                  state_q, state_d;
	logic                             weighted_q;
	logic [pcs_pkg::CNT_W-1:0]        pred_cnt_q, real_cnt_q, x_cnt_q;
	logic                             mismatch_q, missing_q, overflow_q;
	logic [pcs_pkg::SUM_W-1:0]        psum_q, rsum_q, xsum_q;
	logic [pcs_pkg::VAL_W-1:0]        store_mem [pcs_pkg::MAX_LEN];
	logic [pcs_pkg::VAL_W-1:0]        rd_q;
	logic [pcs_pkg::VAL_W-1:0]        real_val_q;
	logic                             out_valid_q;
	pcs_pkg::status_t                 status_q;
	logic [pcs_pkg::STR_W-1:0]        ps_q, rs_q;

	logic                             in_fire;
	pcs_pkg::action_t                 act;
	logic [pcs_pkg::VAL_W-1:0]        mag;
	logic [pcs_pkg::SQ_W-1:0]         sq;
	logic [pcs_pkg::SUM_W-1:0]        sum_sel;
	logic [pcs_pkg::SUM_W:0]          sum_new;
	logic                             sum_ovf;
	logic [pcs_pkg::SUM_W-1:0]        sum_res;
	pcs_pkg::status_t                 ev_status;
	logic                             ev_equal;
	logic                             ev_weigh;
	pcs_pkg::dsq_req_t                dreq;
	pcs_pkg::dsq_res_t                dres;
	logic [pcs_pkg::STR_W-1:0]        dstr;

	assign act     = pcs_pkg::action_t'(action);
	assign in_stall = (state_q != pcs_pkg::ST_IDLE) || out_valid_q;
	assign in_fire = in_valid && !in_stall;

	// signature square, saturating accumulate into the selected sum
	assign mag     = value[23] ? (~value + 1'b1) : value;
	assign sq      = pcs_pkg::SQ_W'(mag) * pcs_pkg::SQ_W'(mag);
	always_comb begin
		case (act)
			pcs_pkg::ACT_PRED_SIG: sum_sel = psum_q;
			pcs_pkg::ACT_REAL_SIG: sum_sel = rsum_q;
			default:               sum_sel = xsum_q;
		endcase
	end
	assign sum_new = {1'b0, sum_sel} + (pcs_pkg::SUM_W + 1)'(sq);
	assign sum_ovf = sum_new > {1'b0, pcs_pkg::SUM_MAX};
	assign sum_res = sum_ovf ? pcs_pkg::SUM_MAX : sum_new[pcs_pkg::SUM_W-1:0];

	// evaluate decision
	always_comb begin
		if (pred_cnt_q == '0)      ev_status = pcs_pkg::STS_EMPTY_PRED;
		else if (x_cnt_q == '0)    ev_status = pcs_pkg::STS_EMPTY_X;
		else if (missing_q)        ev_status = pcs_pkg::STS_MISSING;
		else if (overflow_q)       ev_status = pcs_pkg::STS_TOO_LONG;
		else                       ev_status = pcs_pkg::STS_OK;
	end
	assign ev_equal = !mismatch_q && (real_cnt_q == pred_cnt_q);
	assign ev_weigh = weighted_q && (xsum_q != '0);

	assign dreq.start = (state_q == pcs_pkg::ST_PSTART) || (state_q == pcs_pkg::ST_RSTART);
	assign dreq.sy    = (state_q == pcs_pkg::ST_RSTART) ? rsum_q : psum_q;
	assign dreq.sx    = xsum_q;
	assign dstr       = dres.sat ? pcs_pkg::STRENGTH_ONE : pcs_pkg::ERF_TABLE[dres.idx];

	pcs_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.res    (dres)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pcs_pkg::ST_IDLE: begin
				if (in_fire && act == pcs_pkg::ACT_REAL_PAT &&
				    real_cnt_q < pcs_pkg::CNT_W'(pcs_pkg::MAX_LEN) &&
				    real_cnt_q < pred_cnt_q)
					state_d = pcs_pkg::ST_CMP;
				else if (in_fire && act == pcs_pkg::ACT_EVAL &&
				         ev_status == pcs_pkg::STS_OK && ev_equal && ev_weigh)
					state_d = pcs_pkg::ST_PSTART;
			end
			pcs_pkg::ST_CMP:    state_d = pcs_pkg::ST_IDLE;
			pcs_pkg::ST_PSTART: state_d = pcs_pkg::ST_PWAIT;
			pcs_pkg::ST_PWAIT: begin
				if (dres.done) state_d = pcs_pkg::ST_RSTART;
			end
			pcs_pkg::ST_RSTART: state_d = pcs_pkg::ST_RWAIT;
			pcs_pkg::ST_RWAIT: begin
				if (dres.done) state_d = pcs_pkg::ST_IDLE;
			end
			default: state_d = pcs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pcs_pkg::ST_IDLE;
			weighted_q  <= 1'b0;
			pred_cnt_q  <= '0;
			real_cnt_q  <= '0;
			x_cnt_q     <= '0;
			mismatch_q  <= 1'b0;
			missing_q   <= 1'b0;
			overflow_q  <= 1'b0;
			psum_q      <= '0;
			rsum_q      <= '0;
			xsum_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) weighted_q <= cfg_wdata;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;

			if (in_fire) begin
				if (act != pcs_pkg::ACT_EVAL && act != pcs_pkg::ACT_NONE && missing)
					missing_q <= 1'b1;
				case (act)
					pcs_pkg::ACT_PRED_PAT: begin
						if (pred_cnt_q < pcs_pkg::CNT_W'(pcs_pkg::MAX_LEN))
							pred_cnt_q <= pred_cnt_q + 1'b1;
						else
							overflow_q <= 1'b1;
					end
					pcs_pkg::ACT_REAL_PAT: begin
						if (real_cnt_q < pcs_pkg::CNT_W'(pcs_pkg::MAX_LEN)) begin
							if (real_cnt_q >= pred_cnt_q) mismatch_q <= 1'b1;
							real_cnt_q <= real_cnt_q + 1'b1;
						end else begin
							overflow_q <= 1'b1;
						end
					end
					pcs_pkg::ACT_X_PAT: begin
						if (x_cnt_q < pcs_pkg::CNT_W'(pcs_pkg::MAX_LEN))
							x_cnt_q <= x_cnt_q + 1'b1;
						else
							overflow_q <= 1'b1;
					end
					pcs_pkg::ACT_PRED_SIG, pcs_pkg::ACT_REAL_SIG, pcs_pkg::ACT_X_SIG: begin
						if (!missing) begin
							if (sum_ovf) overflow_q <= 1'b1;
							case (act)
								pcs_pkg::ACT_PRED_SIG: psum_q <= sum_res;
								pcs_pkg::ACT_REAL_SIG: rsum_q <= sum_res;
								default:               xsum_q <= sum_res;
							endcase
						end
					end
					pcs_pkg::ACT_EVAL: begin
						// immediate result unless the erf path is needed
						if (!(ev_status == pcs_pkg::STS_OK && ev_equal && ev_weigh)) begin
							out_valid_q <= 1'b1;
							pred_cnt_q  <= '0;
							real_cnt_q  <= '0;
							x_cnt_q     <= '0;
							mismatch_q  <= 1'b0;
							missing_q   <= 1'b0;
							overflow_q  <= 1'b0;
							psum_q      <= '0;
							rsum_q      <= '0;
							xsum_q      <= '0;
						end
					end
					default: ;
				endcase
			end

			if (state_q == pcs_pkg::ST_CMP && rd_q != real_val_q) mismatch_q <= 1'b1;

			if (state_q == pcs_pkg::ST_RWAIT && dres.done) begin
				out_valid_q <= 1'b1;
				pred_cnt_q  <= '0;
				real_cnt_q  <= '0;
				x_cnt_q     <= '0;
				mismatch_q  <= 1'b0;
				missing_q   <= 1'b0;
				overflow_q  <= 1'b0;
				psum_q      <= '0;
				rsum_q      <= '0;
				xsum_q      <= '0;
			end
		end
	end

	// pattern store and result payload
	always_ff @(posedge clk) begin
		if (in_fire && act == pcs_pkg::ACT_PRED_PAT &&
		    pred_cnt_q < pcs_pkg::CNT_W'(pcs_pkg::MAX_LEN))
			store_mem[pred_cnt_q[pcs_pkg::ADDR_W-1:0]] <= value;
		rd_q       <= store_mem[real_cnt_q[pcs_pkg::ADDR_W-1:0]];
		real_val_q <= value;

		if (in_fire && act == pcs_pkg::ACT_EVAL) begin
			status_q <= ev_status;
			ps_q     <= (ev_status == pcs_pkg::STS_OK && ev_equal) ? pcs_pkg::STRENGTH_ONE : '0;
			rs_q     <= (ev_status == pcs_pkg::STS_OK && ev_equal) ? pcs_pkg::STRENGTH_ONE : '0;
		end
		if (state_q == pcs_pkg::ST_PWAIT && dres.done) ps_q <= dstr;
		if (state_q == pcs_pkg::ST_RWAIT && dres.done) rs_q <= dstr;
	end

	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign predicted_strength = ps_q;
	assign real_strength      = rs_q;

	a_cmp_after_real: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pcs_pkg::ST_CMP |-> $past(in_fire && act == pcs_pkg::ACT_REAL_PAT))
		else $error("compare cycle without a real-pattern beat");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != pcs_pkg::STS_OK |-> ps_q == '0 && rs_q == '0)
		else $error("error status with nonzero strength");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		pred_cnt_q <= pcs_pkg::CNT_W'(pcs_pkg::MAX_LEN) &&
		real_cnt_q <= pcs_pkg::CNT_W'(pcs_pkg::MAX_LEN))
		else $error("pattern count past maximum length");

	a_no_busy_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == pcs_pkg::ST_IDLE)
		else $error("result pending while sequencer busy");

endmodule

// File: src/pcs_divsqrt.sv
// Shared shift-subtract divider and bit-serial square root giving the erf table index.
module pcs_divsqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  pcs_pkg::dsq_req_t req,
	output pcs_pkg::dsq_res_t res
);

	pcs_pkg::ustate_t                 ust_q, ust_d;
	logic [pcs_pkg::REM_W-1:0]        rem_q;
	logic [pcs_pkg::DEN_W-1:0]        den_q;
	logic [pcs_pkg::QUO_W-1:0]        quo_q;
	logic [pcs_pkg::IDX_W-1:0]        root_q;
	logic [pcs_pkg::STEP_W-1:0]       step_q;
	logic                             done_q;
	logic                             sat_q;

	logic [pcs_pkg::DEN_W-1:0]        den_in;
	logic                             big;
	logic [pcs_pkg::REM_W-1:0]        rem2;
	logic                             ge;
	logic [pcs_pkg::IDX_W-1:0]        cand;
	logic [pcs_pkg::QUO_W-1:0]        cand_sq;
	logic                             last;

	assign den_in  = {req.sx, 4'b0000};
	assign big     = {4'b0000, req.sy} >= den_in;
	assign rem2    = {rem_q[pcs_pkg::REM_W-2:0], 1'b0};
	assign ge      = rem2 >= {1'b0, den_q};
	assign cand    = root_q | (pcs_pkg::IDX_W'(1) << step_q);
	assign cand_sq = pcs_pkg::QUO_W'(cand) * pcs_pkg::QUO_W'(cand);
	assign last    = (step_q == '0);

	always_comb begin
		ust_d = ust_q;
		unique case (ust_q)
			pcs_pkg::U_IDLE: begin
				if (req.start && !big) ust_d = pcs_pkg::U_DIV;
			end
			pcs_pkg::U_DIV: begin
				if (last) ust_d = pcs_pkg::U_SQRT;
			end
			pcs_pkg::U_SQRT: begin
				if (last) ust_d = pcs_pkg::U_IDLE;
			end
			default: ust_d = pcs_pkg::U_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ust_q  <= pcs_pkg::U_IDLE;
			done_q <= 1'b0;
		end else begin
			ust_q  <= ust_d;
			done_q <= (ust_q == pcs_pkg::U_IDLE && req.start && big) ||
			          (ust_q == pcs_pkg::U_SQRT && last);
		end
	end

	always_ff @(posedge clk) begin
		unique case (ust_q)
			pcs_pkg::U_IDLE: begin
				if (req.start) begin
					sat_q  <= big;
					rem_q  <= {5'b00000, req.sy};
					den_q  <= den_in;
					quo_q  <= '0;
					root_q <= '0;
					step_q <= pcs_pkg::STEP_W'(pcs_pkg::QUO_W - 1);
				end
			end
			pcs_pkg::U_DIV: begin
				rem_q  <= ge ? (rem2 - {1'b0, den_q}) : rem2;
				quo_q  <= {quo_q[pcs_pkg::QUO_W-2:0], ge};
				step_q <= last ? pcs_pkg::STEP_W'(pcs_pkg::IDX_W - 1) : step_q - 1'b1;
			end
			pcs_pkg::U_SQRT: begin
				if (cand_sq <= quo_q) root_q <= cand;
				if (!last) step_q <= step_q - 1'b1;
			end
			default: ;
		endcase
	end

	assign res.done = done_q;
	assign res.sat  = sat_q;
	assign res.idx  = root_q;

endmodule
